>>> rtl/cubic_newton_root_solver_macros.svh
// assertion macros for the cubic newton root solver checker
// no dependencies; included by the checker file only
`ifndef CUBIC_NEWTON_ROOT_SOLVER_MACROS_SVH
`define CUBIC_NEWTON_ROOT_SOLVER_MACROS_SVH

// same-cycle implication, off during reset
`define CNR_ASSERT_SAME(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("cnr check failed");

// next-cycle implication, off during reset
`define CNR_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("cnr check failed");

// next-cycle implication that also covers reset itself
`define CNR_ASSERT_RESET(name, clk, pre, post) \
   name: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("cnr check failed");

`endif

>>> rtl/cnr_pkg.sv
// shared types, constants and helpers of the cubic newton root solver
// no dependencies; imported by every module of the block
`default_nettype none

package cnr_pkg;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int WORD_WIDTH_DEF = 32;

   // wide intermediate format
   localparam int WIDE_W  = 64;
   localparam int DIGIT_W = 16;

   typedef logic signed [WIDE_W-1:0] wide_type;

   localparam logic [WIDE_W-1:0] WIDE_MAX = {1'b0, {(WIDE_W-1){1'b1}}};
   localparam logic signed [WIDE_W+1:0] WIDE_MAX_X = {2'b00, WIDE_MAX};

   // field widths
   localparam int MAXIT_W  = 12;
   localparam int TOL_W    = 5;
   localparam int ITER_W   = 13;
   localparam int STATUS_W = 2;

   localparam logic [STATUS_W-1:0] STATUS_CONVERGED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_LIMIT      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_DERIV = 2'd2;

   // register map
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_A    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_B    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_C    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_D    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TOL_SHIFT = 3'd5;

   localparam logic [MAXIT_W-1:0] MAXIT_RESET = 12'd1000;
   localparam logic [TOL_W-1:0]   TOL_RESET   = 5'd17;

   // symmetric saturation of a sum to +-(2^63 - 1)
   function automatic wide_type sat_wide(input logic signed [WIDE_W+1:0] v);
      wide_type r;
      if (v > WIDE_MAX_X) begin
         r = wide_type'(WIDE_MAX);
      end else if (v < -WIDE_MAX_X) begin
         r = -wide_type'(WIDE_MAX);
      end else begin
         r = v[WIDE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

>>> rtl/cnr_mul.sv
// multi-cycle fixed-point multiply with rounding and saturating add
// depends on cnr_pkg; used by the cubic newton root solver sequencer
`default_nettype none

module cnr_mul
   import cnr_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire wide_type                     opd,
   input  wire logic signed [WORD_WIDTH-1:0] x,
   input  wire wide_type                     addend,
   output      wide_type                     result,
   output      logic                         done
);

   localparam int NDIG  = (WORD_WIDTH + DIGIT_W - 1) / DIGIT_W;
   localparam int XW    = NDIG * DIGIT_W;
   localparam int AW    = WIDE_W + XW;
   localparam int PP_W  = WIDE_W + DIGIT_W;
   localparam int TW    = AW + FRAC_BITS + 1;
   localparam int CNT_W = $clog2(NDIG + 3);

   localparam logic [CNT_W-1:0] CNT_LAST_PP = CNT_W'(NDIG - 1);
   localparam logic [CNT_W-1:0] CNT_LAST_AC = CNT_W'(NDIG);
   localparam logic [CNT_W-1:0] CNT_ROUND   = CNT_W'(NDIG + 1);
   localparam logic [CNT_W-1:0] CNT_ADD     = CNT_W'(NDIG + 2);
   localparam logic [TW-1:0]    HALF        = TW'(1) << (FRAC_BITS - 1);

   logic                   busy_ff, busy_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [WIDE_W-1:0]      mag_ff, mag_in;
   logic [XW-1:0]          xmag_ff, xmag_in;
   logic                   neg_ff, neg_in;
   wide_type               addend_ff, addend_in;
   logic [PP_W-1:0]        pp_ff, pp_in;
   logic [AW-1:0]          acc_ff, acc_in;
   wide_type               rnd_ff, rnd_in;
   wide_type               result_ff, result_in;

   logic [WORD_WIDTH-1:0]  x_abs;
   logic [TW-1:0]          t_sum;
   logic [TW-1:0]          t_shr;
   logic [WIDE_W-2:0]      r_mag;
   logic signed [WIDE_W+1:0] s_sum;

   always_comb begin
      x_abs = x[WORD_WIDTH-1] ? WORD_WIDTH'(-x) : WORD_WIDTH'(x);
      t_sum = TW'(acc_ff) + HALF;
      t_shr = t_sum >> FRAC_BITS;
      r_mag = (|t_shr[TW-1:WIDE_W-1]) ? WIDE_MAX[WIDE_W-2:0] : t_shr[WIDE_W-2:0];
      s_sum = (WIDE_W+2)'(rnd_ff) + (WIDE_W+2)'(addend_ff);

      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      mag_in    = mag_ff;
      xmag_in   = xmag_ff;
      neg_in    = neg_ff;
      addend_in = addend_ff;
      pp_in     = pp_ff;
      acc_in    = acc_ff;
      rnd_in    = rnd_ff;
      result_in = result_ff;

      if (!busy_ff) begin
         if (start) begin
            busy_in   = 1'b1;
            cnt_in    = '0;
            mag_in    = opd[WIDE_W-1] ? WIDE_W'(-opd) : WIDE_W'(opd);
            xmag_in   = XW'(x_abs);
            neg_in    = opd[WIDE_W-1] ^ x[WORD_WIDTH-1];
            addend_in = addend;
            acc_in    = '0;
         end
      end else begin
         cnt_in = cnt_ff + 1'b1;
         // digit products, msb digit first
         if (cnt_ff <= CNT_LAST_PP) begin
            pp_in   = PP_W'(mag_ff) * PP_W'(xmag_ff[XW-1 -: DIGIT_W]);
            xmag_in = xmag_ff << DIGIT_W;
         end
         if (cnt_ff != '0 && cnt_ff <= CNT_LAST_AC) begin
            acc_in = (acc_ff << DIGIT_W) + AW'(pp_ff);
         end
         if (cnt_ff == CNT_ROUND) begin
            rnd_in = neg_ff ? -wide_type'({1'b0, r_mag}) : wide_type'({1'b0, r_mag});
         end
         if (cnt_ff == CNT_ADD) begin
            result_in = sat_wide(s_sum);
            done_in   = 1'b1;
            busy_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff    <= mag_in;
      xmag_ff   <= xmag_in;
      neg_ff    <= neg_in;
      addend_ff <= addend_in;
      pp_ff     <= pp_in;
      acc_ff    <= acc_in;
      rnd_ff    <= rnd_in;
      result_ff <= result_in;
   end

   assign result = result_ff;
   assign done   = done_ff;

endmodule

`default_nettype wire

>>> rtl/cnr_div.sv
// bit-serial restoring divider for the fixed-point quotient f / f'
// depends on cnr_pkg; used by the cubic newton root solver sequencer
`default_nettype none

module cnr_div
   import cnr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire wide_type num,
   input  wire wide_type den,
   output      wide_type quot,
   output      logic     done
);

   // rounded numerator (|num| << FRAC_BITS) + |den|/2 fits in NW bits
   localparam int NW    = WIDE_W + FRAC_BITS;
   localparam int IDX_W = $clog2(NW);

   localparam logic [IDX_W-1:0] IDX_TOP  = IDX_W'(NW - 1);
   localparam logic [IDX_W-1:0] IDX_OVER = IDX_W'(WIDE_W - 1);

   logic                busy_ff, busy_in;
   logic                fin_ff, fin_in;
   logic                done_ff, done_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [NW-1:0]       num_ff, num_in;
   logic [WIDE_W-1:0]   den_ff, den_in;
   logic [WIDE_W-1:0]   rem_ff, rem_in;
   logic [WIDE_W-2:0]   q_ff, q_in;
   logic                over_ff, over_in;
   logic                neg_ff, neg_in;
   wide_type            quot_ff, quot_in;

   logic [WIDE_W-1:0]   un;
   logic [WIDE_W-1:0]   ud;
   logic [WIDE_W:0]     rem2;
   logic [WIDE_W:0]     rem_sub;
   logic                ge;
   logic [WIDE_W-2:0]   q_fin;

   always_comb begin
      un      = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
      ud      = den[WIDE_W-1] ? WIDE_W'(-den) : WIDE_W'(den);
      rem2    = {rem_ff, num_ff[NW-1]};
      rem_sub = rem2 - {1'b0, den_ff};
      ge      = (rem2 >= {1'b0, den_ff});
      q_fin   = over_ff ? WIDE_MAX[WIDE_W-2:0] : q_ff;

      busy_in = busy_ff;
      fin_in  = 1'b0;
      done_in = 1'b0;
      idx_in  = idx_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      over_in = over_ff;
      neg_in  = neg_ff;
      quot_in = quot_ff;

      if (busy_ff) begin
         rem_in  = ge ? rem_sub[WIDE_W-1:0] : rem2[WIDE_W-1:0];
         num_in  = num_ff << 1;
         q_in    = {q_ff[WIDE_W-3:0], ge};
         // a quotient bit at weight 2^63 or above means overflow
         over_in = over_ff | (ge & (idx_ff >= IDX_OVER));
         idx_in  = idx_ff - 1'b1;
         if (idx_ff == '0) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         quot_in = neg_ff ? -wide_type'({1'b0, q_fin}) : wide_type'({1'b0, q_fin});
         done_in = 1'b1;
      end else if (start) begin
         busy_in = 1'b1;
         idx_in  = IDX_TOP;
         num_in  = (NW'(un) << FRAC_BITS) + NW'(ud >> 1);
         den_in  = ud;
         rem_in  = '0;
         q_in    = '0;
         over_in = 1'b0;
         neg_in  = num[WIDE_W-1] ^ den[WIDE_W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      q_ff    <= q_in;
      over_ff <= over_in;
      neg_ff  <= neg_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

>>> rtl/cubic_newton_root_solver.sv
// top level of the cubic newton root solver: register file and sequencer
// depends on cnr_pkg, cnr_mul and cnr_div
`default_nettype none

// Newton search for a root of a*x^3 + b*x^2 + c*x + d, all signed fixed point.
// csr port: a write at any clock with csr_wr_en high sets the register that
//   csr_index selects (coef a, b, c, d, iteration limit, tolerance shift);
//   write only while the block is idle
// req channel: one item is the initial guess; it is taken when req_valid is
//   high and req_stall low. req_stall stays high for the whole search.
// rsp channel: one item per guess: root, iteration count and status
//   (converged, iteration limit, zero derivative)
// one iteration runs five multiplies on the shared multiply unit, a check of
//   the derivative, a 1-bit-per-cycle divide and the stop tests
// the result sits in an output register; a new guess is taken while it
//   waits. A finished search holds in its last state while that register is
//   full and the receiver stalls.
// reset (synchronous) returns coefficients to 0, 0, 1.0, 0, the iteration
//   limit to 1000 and the tolerance shift to 17, and drops rsp_valid

module cubic_newton_root_solver
   import cnr_pkg::*;
#(
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int WORD_WIDTH = WORD_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // configuration
   input  wire logic                         csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]         csr_index,
   input  wire logic [WORD_WIDTH-1:0]        csr_wr_data,
   // guess in
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic signed [WORD_WIDTH-1:0] req_initial_guess,
   // result out
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic signed [WORD_WIDTH-1:0] rsp_root,
   output      logic [ITER_W-1:0]            rsp_iterations,
   output      logic [STATUS_W-1:0]          rsp_status
);

   localparam int W = WORD_WIDTH;

   // sequencer states
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_MUL_GO   = 3'd1;
   localparam logic [2:0] S_MUL_WAIT = 3'd2;
   localparam logic [2:0] S_CHECK    = 3'd3;
   localparam logic [2:0] S_DIV_WAIT = 3'd4;
   localparam logic [2:0] S_TEST     = 3'd5;
   localparam logic [2:0] S_DONE     = 3'd6;

   // horner steps on the multiply unit
   localparam logic [2:0] OP_F1 = 3'd0;   // a*x + b
   localparam logic [2:0] OP_F2 = 3'd1;   // f*x + c
   localparam logic [2:0] OP_F3 = 3'd2;   // f*x + d
   localparam logic [2:0] OP_P1 = 3'd3;   // 3a*x + 2b
   localparam logic [2:0] OP_P2 = 3'd4;   // f'*x + c

   localparam logic signed [WIDE_W+1:0] WORD_MAX_X = (66'sd1 <<< (W - 1)) - 66'sd1;
   localparam logic signed [WIDE_W+1:0] WORD_MIN_X = -WORD_MAX_X - 66'sd1;
   localparam logic signed [W-1:0]      COEF_C_RESET = W'(1) << FRAC_BITS;

   // configuration registers
   logic signed [W-1:0]  coef_a_ff, coef_a_in;
   logic signed [W-1:0]  coef_b_ff, coef_b_in;
   logic signed [W-1:0]  coef_c_ff, coef_c_in;
   logic signed [W-1:0]  coef_d_ff, coef_d_in;
   logic [MAXIT_W-1:0]   maxit_ff, maxit_in;
   logic [TOL_W-1:0]     tol_ff, tol_in;

   // sequencer and datapath
   logic [2:0]           state_ff, state_in;
   logic [2:0]           op_ff, op_in;
   logic signed [W-1:0]  x_ff, x_in;
   logic signed [W-1:0]  xn_ff, xn_in;
   logic [ITER_W-1:0]    count_ff, count_in;
   wide_type             f_ff, f_in;
   wide_type             fp_ff, fp_in;
   logic [STATUS_W-1:0]  status_ff, status_in;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [W-1:0]  rsp_root_ff, rsp_root_in;
   logic [ITER_W-1:0]    rsp_iterations_ff, rsp_iterations_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;

   // shared units
   logic                 mul_start;
   wide_type             mul_opd;
   wide_type             mul_addend;
   wide_type             mul_result;
   logic                 mul_done;
   logic                 div_start;
   wide_type             div_quot;
   logic                 div_done;

   // helpers
   wide_type                 a_w, b_w, c_w, d_w;
   logic signed [WIDE_W+1:0] xn_sum;
   logic signed [W:0]        dx;
   logic [W:0]               dx_mag;
   logic [W-1:0]             x_mag;
   logic [W-1:0]             thr;
   logic                     converged;
   logic                     at_limit;
   logic                     rsp_load;

   // register file writes
   always_comb begin
      coef_a_in = coef_a_ff;
      coef_b_in = coef_b_ff;
      coef_c_in = coef_c_ff;
      coef_d_in = coef_d_ff;
      maxit_in  = maxit_ff;
      tol_in    = tol_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_COEF_A:    coef_a_in = csr_wr_data;
            CSR_COEF_B:    coef_b_in = csr_wr_data;
            CSR_COEF_C:    coef_c_in = csr_wr_data;
            CSR_COEF_D:    coef_d_in = csr_wr_data;
            CSR_MAX_ITER:  maxit_in  = csr_wr_data[MAXIT_W-1:0];
            CSR_TOL_SHIFT: tol_in    = csr_wr_data[TOL_W-1:0];
            default:       ;   // unmapped index, write dropped
         endcase
      end
   end

   // coefficients in the wide format; 3a and 2b never saturate here
   always_comb begin
      a_w = WIDE_W'(coef_a_ff);
      b_w = WIDE_W'(coef_b_ff);
      c_w = WIDE_W'(coef_c_ff);
      d_w = WIDE_W'(coef_d_ff);
   end

   // operand select for the multiply unit
   always_comb begin
      unique case (op_ff)
         OP_F1: begin
            mul_opd    = a_w;
            mul_addend = b_w;
         end
         OP_F2: begin
            mul_opd    = f_ff;
            mul_addend = c_w;
         end
         OP_F3: begin
            mul_opd    = f_ff;
            mul_addend = d_w;
         end
         OP_P1: begin
            mul_opd    = a_w + a_w + a_w;
            mul_addend = b_w + b_w;
         end
         OP_P2: begin
            mul_opd    = fp_ff;
            mul_addend = c_w;
         end
         default: begin
            mul_opd    = '0;
            mul_addend = '0;
         end
      endcase
   end

   assign mul_start = (state_ff == S_MUL_GO);
   assign div_start = (state_ff == S_CHECK) && (fp_ff != '0);

   cnr_mul #(
      .FRAC_BITS  (FRAC_BITS),
      .WORD_WIDTH (WORD_WIDTH)
   ) u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .opd    (mul_opd),
      .x      (x_ff),
      .addend (mul_addend),
      .result (mul_result),
      .done   (mul_done)
   );

   cnr_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (f_ff),
      .den   (fp_ff),
      .quot  (div_quot),
      .done  (div_done)
   );

   // x - f/f' clamped to the word range, then the stop tests
   always_comb begin
      xn_sum    = (WIDE_W+2)'(x_ff) - (WIDE_W+2)'(div_quot);
      dx        = (W+1)'(xn_ff) - (W+1)'(x_ff);
      dx_mag    = dx[W] ? (W+1)'(-dx) : (W+1)'(dx);
      x_mag     = x_ff[W-1] ? W'(-x_ff) : W'(x_ff);
      thr       = x_mag >> tol_ff;
      converged = (dx_mag < {1'b0, thr});
      at_limit  = (count_ff > ITER_W'(maxit_ff));
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      x_in      = x_ff;
      xn_in     = xn_ff;
      count_in  = count_ff;
      f_in      = f_ff;
      fp_in     = fp_ff;
      status_in = status_ff;
      rsp_load  = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in     = req_initial_guess;
               count_in = '0;
               op_in    = OP_F1;
               state_in = S_MUL_GO;
            end
         end
         S_MUL_GO: begin
            state_in = S_MUL_WAIT;
         end
         S_MUL_WAIT: begin
            if (mul_done) begin
               if (op_ff == OP_P1 || op_ff == OP_P2) begin
                  fp_in = mul_result;
               end else begin
                  f_in = mul_result;
               end
               if (op_ff == OP_P2) begin
                  state_in = S_CHECK;
               end else begin
                  op_in    = op_ff + 3'd1;
                  state_in = S_MUL_GO;
               end
            end
         end
         S_CHECK: begin
            // flat derivative ends the run at the current estimate
            if (fp_ff == '0) begin
               status_in = STATUS_ZERO_DERIV;
               state_in  = S_DONE;
            end else begin
               state_in = S_DIV_WAIT;
            end
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               if (xn_sum > WORD_MAX_X) begin
                  xn_in = W'(WORD_MAX_X);
               end else if (xn_sum < WORD_MIN_X) begin
                  xn_in = W'(WORD_MIN_X);
               end else begin
                  xn_in = xn_sum[W-1:0];
               end
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            // convergence wins over the limit; result is x, not x_next
            priority if (converged) begin
               status_in = STATUS_CONVERGED;
               state_in  = S_DONE;
            end else if (at_limit) begin
               status_in = STATUS_LIMIT;
               state_in  = S_DONE;
            end else begin
               x_in     = xn_ff;
               count_in = count_ff + 1'b1;
               op_in    = OP_F1;
               state_in = S_MUL_GO;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in      = rsp_valid_ff;
      rsp_root_in       = rsp_root_ff;
      rsp_iterations_in = rsp_iterations_ff;
      rsp_status_in     = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in      = 1'b1;
         rsp_root_in       = x_ff;
         rsp_iterations_in = count_ff;
         rsp_status_in     = status_ff;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a_ff    <= '0;
         coef_b_ff    <= '0;
         coef_c_ff    <= COEF_C_RESET;
         coef_d_ff    <= '0;
         maxit_ff     <= MAXIT_RESET;
         tol_ff       <= TOL_RESET;
         state_ff     <= S_IDLE;
         op_ff        <= OP_F1;
         rsp_valid_ff <= 1'b0;
      end else begin
         coef_a_ff    <= coef_a_in;
         coef_b_ff    <= coef_b_in;
         coef_c_ff    <= coef_c_in;
         coef_d_ff    <= coef_d_in;
         maxit_ff     <= maxit_in;
         tol_ff       <= tol_in;
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff              <= x_in;
      xn_ff             <= xn_in;
      count_ff          <= count_in;
      f_ff              <= f_in;
      fp_ff             <= fp_in;
      status_ff         <= status_in;
      rsp_root_ff       <= rsp_root_in;
      rsp_iterations_ff <= rsp_iterations_in;
      rsp_status_ff     <= rsp_status_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_root       = rsp_root_ff;
   assign rsp_iterations = rsp_iterations_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

>>> rtl/cnr_checker.sv
// port-level checks of the cubic newton root solver, bound to the top level
// depends on cnr_pkg and cubic_newton_root_solver_macros.svh
`default_nettype none

`include "cubic_newton_root_solver_macros.svh"

module cnr_checker
   import cnr_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [ITER_W-1:0]   rsp_iterations,
   input wire logic [STATUS_W-1:0] rsp_status
);

   // a stalled result item stays offered
   `CNR_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // a taken guess makes the block busy at once
   `CNR_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)

   // the limit stop only happens after at least one update
   `CNR_ASSERT_SAME(a_limit_counts, clock, reset, rsp_valid && rsp_status == STATUS_LIMIT, rsp_iterations != '0)

   // reset leaves no result pending and the input open
   `CNR_ASSERT_RESET(a_reset_clean, clock, reset, !rsp_valid && !req_stall)

endmodule

bind cubic_newton_root_solver cnr_checker u_cnr_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_iterations (rsp_iterations),
   .rsp_status     (rsp_status)
);

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 100ps
// testbench of cubic_newton_root_solver: directed and random initial guesses over a series
// of coefficient sets, every result checked field by field against a bit-exact predictor
// depends on cnr_pkg and the rtl of cubic_newton_root_solver

module tb;
   import cnr_pkg::*;

   localparam int WORD_W = WORD_WIDTH_DEF;
   localparam int FRAC_W = FRAC_BITS_DEF;
   localparam int Q_ONE  = 1 << FRAC_W;

   // symmetric saturation bound of the wide intermediates and the word range
   localparam longint WIDE_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam longint WORD_TOP = 64'sd2147483647;
   localparam longint WORD_BOT = -64'sd2147483648;

   // register indexes past the end of the map, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   typedef logic signed [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type            root;
      logic [ITER_W-1:0]   iterations;
      logic [STATUS_W-1:0] status;
   } root_result_type;

   // predictor plus the queue of roots still owed by the block
   class root_tracker_type;
      longint      coef_a, coef_b, coef_c, coef_d;
      int unsigned iter_limit;
      int unsigned tol_shift;
      root_result_type pending_roots[$];
      int failures;

      function new();
         coef_a     = 0;
         coef_b     = 0;
         coef_c     = longint'(Q_ONE);
         coef_d     = 0;
         iter_limit = 32'(MAXIT_RESET);
         tol_shift  = 32'(TOL_RESET);
         failures   = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         case (idx)
            CSR_COEF_A:    coef_a = longint'(word_type'(data));
            CSR_COEF_B:    coef_b = longint'(word_type'(data));
            CSR_COEF_C:    coef_c = longint'(word_type'(data));
            CSR_COEF_D:    coef_d = longint'(word_type'(data));
            CSR_MAX_ITER:  iter_limit = 32'(data[MAXIT_W-1:0]);
            CSR_TOL_SHIFT: tol_shift = 32'(data[TOL_W-1:0]);
            default: ;
         endcase
      endfunction

      function logic [63:0] magn(longint v);
         return (v < 0) ? 64'(-v) : 64'(v);
      endfunction

      function longint sat_sum(longint p, longint q);
         logic signed [65:0] s;
         s = 66'(p) + 66'(q);
         if (s > 66'(WIDE_TOP)) return WIDE_TOP;
         if (s < -66'(WIDE_TOP)) return -WIDE_TOP;
         return longint'(s[63:0]);
      endfunction

      // product scaled back by the fraction bits, magnitude rounded half away from zero
      function longint mul_fx(longint p, longint q);
         logic [127:0] prod;
         logic         neg;
         neg  = (p < 0) != (q < 0);
         prod = {64'd0, magn(p)} * {64'd0, magn(q)};
         prod = prod + (128'd1 << (FRAC_W - 1));
         prod = prod >> FRAC_W;
         if (prod > {64'd0, WIDE_TOP}) prod = {64'd0, WIDE_TOP};
         return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
      endfunction

      // (n << frac) / d, magnitude rounded half away from zero; d is never zero here
      function longint div_fx(longint n, longint d);
         logic [127:0] num, den, quo;
         logic         neg;
         neg = (n < 0) != (d < 0);
         den = {64'd0, magn(d)};
         num = ({64'd0, magn(n)} << FRAC_W) + (den >> 1);
         quo = num / den;
         if (quo > {64'd0, WIDE_TOP}) quo = {64'd0, WIDE_TOP};
         return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
      endfunction

      function root_result_type solve_cubic(word_type guess);
         root_result_type res;
         longint          x, xn, f, fp, a3, b2;
         logic [63:0]     diff, thr;
         int unsigned     count;
         x     = longint'(guess);
         a3    = sat_sum(sat_sum(coef_a, coef_a), coef_a);
         b2    = sat_sum(coef_b, coef_b);
         count = 0;
         res.status = STATUS_LIMIT;
         while (1'b1) begin
            f  = sat_sum(mul_fx(coef_a, x), coef_b);
            f  = sat_sum(mul_fx(f, x), coef_c);
            f  = sat_sum(mul_fx(f, x), coef_d);
            fp = sat_sum(mul_fx(a3, x), b2);
            fp = sat_sum(mul_fx(fp, x), coef_c);
            if (fp == 0) begin
               res.status = STATUS_ZERO_DERIV;
               break;
            end
            xn = sat_sum(x, -div_fx(f, fp));
            if (xn > WORD_TOP) xn = WORD_TOP;
            else if (xn < WORD_BOT) xn = WORD_BOT;
            diff = magn(xn - x);
            thr  = magn(x) >> tol_shift;
            if (diff < thr) begin
               res.status = STATUS_CONVERGED;
               break;
            end
            if (count > iter_limit) begin
               res.status = STATUS_LIMIT;
               break;
            end
            x = xn;
            count++;
         end
         res.root       = x[WORD_W-1:0];
         res.iterations = count[ITER_W-1:0];
         return res;
      endfunction

      function void note_guess(word_type guess);
         pending_roots.push_back(solve_cubic(guess));
      endfunction

      function void check_root(word_type root, logic [ITER_W-1:0] iterations,
                               logic [STATUS_W-1:0] status);
         root_result_type want;
         if (pending_roots.size() == 0) begin
            $error("unexpected result: root %0d iterations %0d status %0d",
                   root, iterations, status);
            failures++;
            return;
         end
         want = pending_roots.pop_front();
         if (root !== want.root) begin
            $error("root: expected %0d, actual %0d", want.root, root);
            failures++;
         end
         if (iterations !== want.iterations) begin
            $error("iterations: expected %0d, actual %0d", want.iterations, iterations);
            failures++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            failures++;
         end
      endfunction

      function int pending();
         return pending_roots.size();
      endfunction
   endclass

   logic                 clock             = 1'b0;
   logic                 reset             = 1'b1;
   logic                 csr_wr_en         = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index         = '0;
   logic [WORD_W-1:0]    csr_wr_data       = '0;
   logic                 req_valid         = 1'b0;
   logic                 req_stall;
   word_type             req_initial_guess = '0;
   logic                 rsp_valid;
   logic                 rsp_stall         = 1'b0;
   word_type             rsp_root;
   logic [ITER_W-1:0]    rsp_iterations;
   logic [STATUS_W-1:0]  rsp_status;

   root_tracker_type sb;
   int               stall_left = 0;

   cubic_newton_root_solver u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_initial_guess (req_initial_guess),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_root          (rsp_root),
      .rsp_iterations    (rsp_iterations),
      .rsp_status        (rsp_status)
   );

   // 2 ns clock
   initial begin
      forever #1 clock = ~clock;
   end

   // hard stop well past the slowest legal run (the 4096-update item)
   initial begin
      #20_000_000;
      $display("Verification failed");
      $finish;
   end

   // mostly short spans, now and then a long one
   function automatic int pick_span();
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 50);
      return $urandom_range(0, 3);
   endfunction

   function automatic word_type pick_coef();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return word_type'($urandom);
         2: return $urandom_range(0, 1) ? word_type'(32'h7FFF_FFFF) : word_type'(32'h8000_0000);
         3: return word_type'((int'($urandom_range(0, 8)) - 4) * Q_ONE);
         default: return word_type'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      endcase
   endfunction

   function automatic word_type pick_guess();
      case ($urandom_range(0, 7))
         0: return word_type'(32'h7FFF_FFFF);
         1: return word_type'(32'h8000_0000);
         2: return '0;
         3, 4: return word_type'($urandom);
         default: return word_type'(int'($urandom_range(0, 12 * Q_ONE)) - 6 * Q_ONE);
      endcase
   endfunction

   // receiver back-pressure: random stall level held for a random span
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
      end else begin
         rsp_stall  <= ($urandom_range(0, 2) == 0);
         stall_left = pick_span();
      end
   end

   // every accepted result goes to the tracker
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         sb.check_root(rsp_root, rsp_iterations, rsp_status);
      end
   end

   // one register write per clock; the caller drops the write enable
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   // full register set plus one write to an unmapped index; only called while idle
   task automatic load_config(input word_type ca, cb, cc, cd,
                              input logic [WORD_W-1:0] iter_data, tol_data);
      repeat (4) @(posedge clock);
      csr_put(CSR_COEF_A, ca);
      csr_put(CSR_COEF_B, cb);
      csr_put(CSR_COEF_C, cc);
      csr_put(CSR_COEF_D, cd);
      csr_put(CSR_MAX_ITER, iter_data);
      csr_put(CSR_TOL_SHIFT, tol_data);
      csr_put($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // valid stays up across back-to-back items; it only drops for a gap or a drain
   task automatic send_guess(input word_type guess, input int gap, input bit drain);
      req_valid         <= 1'b1;
      req_initial_guess <= guess;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      sb.note_guess(guess);
      if (gap > 0 || drain) req_valid <= 1'b0;
      if (drain) wait_drained();
      repeat (gap) @(posedge clock);
   endtask

   initial begin
      int r1, r2, r3, sgn, drain_at;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset cubic f(x) = x from zero: the threshold stays zero, so the search
      // runs out the widest iteration limit (4096 updates)
      load_config('0, '0, word_type'(Q_ONE), '0, 32'd4095, 32'd17);
      send_guess('0, 0, 1'b1);

      // derivative is zero everywhere: stops before any update
      load_config('0, '0, '0, word_type'(32'h7FFF_FFFF), 32'd1000, 32'd31);
      send_guess(word_type'(32'h7FFF_FFFF), pick_span(), 1'b0);
      send_guess(word_type'(32'h8000_0000), pick_span(), 1'b0);
      send_guess('0, pick_span(), 1'b0);
      send_guess(word_type'(1), pick_span(), 1'b0);
      send_guess(word_type'(-1), pick_span(), 1'b1);

      // f(x) = x - 3 with a zero limit: from the extreme guesses the second pass both
      // converges and is past the limit, convergence must win; 5.0 converges on the first pass
      load_config('0, '0, word_type'(Q_ONE), word_type'(-3 * Q_ONE), 32'd0, 32'd1);
      send_guess(word_type'(32'h7FFF_FFFF), pick_span(), 1'b0);
      send_guess(word_type'(32'h8000_0000), pick_span(), 1'b0);
      send_guess(word_type'(5 * Q_ONE), pick_span(), 1'b1);

      // shift of 31 leaves a zero threshold, so only the limit stops it
      load_config('0, '0, word_type'(Q_ONE), word_type'(-3 * Q_ONE), 32'd0, 32'd31);
      send_guess(word_type'(5 * Q_ONE), pick_span(), 1'b1);

      // shift of zero: threshold is |x| itself
      load_config('0, '0, word_type'(Q_ONE), word_type'(-3 * Q_ONE), 32'd0, 32'd0);
      send_guess(word_type'(5 * Q_ONE), pick_span(), 1'b1);

      // extreme coefficients drive the wide terms and the word clamp into saturation
      load_config(word_type'(32'h7FFF_FFFF), word_type'(32'h8000_0000),
                  word_type'(32'h7FFF_FFFF), word_type'(32'h8000_0000), 32'd3, 32'd5);
      send_guess(word_type'(32'h7FFF_FFFF), pick_span(), 1'b0);
      send_guess(word_type'(32'h8000_0000), pick_span(), 1'b0);
      send_guess(word_type'(Q_ONE), pick_span(), 1'b0);
      send_guess('0, pick_span(), 1'b1);
      load_config(word_type'(32'h8000_0000), word_type'(32'h7FFF_FFFF),
                  word_type'(32'h8000_0000), word_type'(32'h7FFF_FFFF), 32'd2, 32'd0);
      send_guess(word_type'(32'h7FFF_FFFF), pick_span(), 1'b0);
      send_guess(word_type'(-Q_ONE), pick_span(), 1'b1);

      // x^3 - 2: converges from 1.0 and 100.0; from -1.0 the first update
      // lands on zero where the derivative vanishes
      load_config(word_type'(Q_ONE), '0, '0, word_type'(-2 * Q_ONE), 32'd1000, 32'd17);
      send_guess(word_type'(Q_ONE), pick_span(), 1'b0);
      send_guess(word_type'(100 * Q_ONE), pick_span(), 1'b0);
      send_guess(word_type'(-Q_ONE), pick_span(), 1'b1);

      // random phases: even ones are cubics with small integer roots (plus a
      // little offset on d) so most searches converge, odd ones are arbitrary
      // coefficients with tight limits and junk in the unused register bits
      for (int p = 0; p < 8; p++) begin
         if (p % 2 == 0) begin
            r1  = int'($urandom_range(0, 8)) - 4;
            r2  = int'($urandom_range(0, 8)) - 4;
            r3  = int'($urandom_range(0, 8)) - 4;
            sgn = $urandom_range(0, 1) ? 1 : -1;
            load_config(word_type'(sgn * Q_ONE),
                        word_type'(-sgn * (r1 + r2 + r3) * Q_ONE),
                        word_type'(sgn * (r1 * r2 + r1 * r3 + r2 * r3) * Q_ONE),
                        word_type'(-sgn * r1 * r2 * r3 * Q_ONE
                                   + int'($urandom_range(0, 255)) - 128),
                        $urandom_range(8, 40), $urandom_range(6, 20));
         end else begin
            load_config(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                        ($urandom & ~32'hFFF) | $urandom_range(0, 12),
                        ($urandom & ~32'h1F) | $urandom_range(0, 31));
         end
         // somewhere mid-phase the sender holds off until all results are back
         drain_at = $urandom_range(0, 10);
         for (int i = 0; i < 12; i++) begin
            send_guess(pick_guess(), pick_span(), (i == drain_at) || (i == 11));
         end
      end

      wait_drained();
      // quiet tail to catch any stray result
      repeat (300) @(posedge clock);
      if (sb.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+rtl
rtl/cnr_pkg.sv
rtl/cnr_mul.sv
rtl/cnr_div.sv
rtl/cubic_newton_root_solver.sv
rtl/cnr_checker.sv
verif/tb.sv
